>>> design/stwf_pkg.sv
// ----------------------------------------------------------------------------
// stwf_pkg
// Shared types and constants of the sum-threshold window flagger.
// ----------------------------------------------------------------------------
`default_nettype none

package stwf_pkg;

    localparam int VALUE_W    = 32;
    localparam int COL_OUT_W  = 12;
    localparam int LEN_W      = 7;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;
    localparam logic [THR_W-1:0] THR_RESET = 31'h7FFF_FFFF;

    // One window entry without its column.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               flagged;
    } t_entry;

    // Broadcast control for the row of window cells, already gated by the push.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> design/stwf_cell.sv
// ----------------------------------------------------------------------------
// stwf_cell
// One window slot. Slot 0 holds the oldest entry; on a pop every slot takes
// the entry of its upper neighbor, and the slot at the target index takes
// the new item.
// ----------------------------------------------------------------------------
`default_nettype none

module stwf_cell
    import stwf_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int FILL_W     = 7,
    parameter int COL_W      = 12
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [FILL_W-1:0] i_target,
    input  wire t_entry            i_new_entry,
    input  wire logic [COL_W-1:0]  i_new_col,
    input  wire t_entry            i_next_entry,
    input  wire logic [COL_W-1:0]  i_next_col,
    output t_entry                 o_entry,
    output logic [COL_W-1:0]       o_col
);

    t_entry             r_entry;
    logic [COL_W-1:0]   r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_target == FILL_W'(CELL_INDEX))) begin
            r_entry <= i_new_entry;
            r_col   <= i_new_col;
        end else if (i_ctl.shift) begin
            r_entry <= i_next_entry;
            r_col   <= i_next_col;
        end
    end

    assign o_entry = r_entry;
    assign o_col   = r_col;

endmodule

`default_nettype wire

>>> design/stwf_test.sv
// ----------------------------------------------------------------------------
// stwf_test
// Threshold test of a full window: magnitude and limit product in one stage,
// compare into the output register in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module stwf_test
    import stwf_pkg::*;
#(
    parameter int SUM_W = 39,
    parameter int CNT_W = 7,
    parameter int COL_W = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [SUM_W-1:0]     i_sum,
    input  wire logic [CNT_W-1:0]     i_count,
    input  wire logic [COL_W-1:0]     i_first,
    input  wire logic [COL_W-1:0]     i_last,
    input  wire logic [THR_W-1:0]     i_threshold,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [COL_OUT_W-1:0]      o_first_column,
    output logic [COL_OUT_W-1:0]      o_last_column
);

    localparam int PROD_W = THR_W + CNT_W;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    logic               r_s2_valid;
    logic [SUM_W-1:0]   r_s2_mag;
    logic [PROD_W-1:0]  r_s2_limit;
    logic               r_s2_nonzero;
    logic [COL_W-1:0]   r_s2_first;
    logic [COL_W-1:0]   r_s2_last;

    logic               r_o_valid;
    logic [COL_W-1:0]   r_o_first;
    logic [COL_W-1:0]   r_o_last;

    logic               out_ready;
    logic [SUM_W-1:0]   mag;
    logic               fire;

    assign out_ready = !r_o_valid || !i_stall;
    assign o_ready   = !r_s2_valid || out_ready;

    // The sum is two's complement; its magnitude always fits as unsigned.
    assign mag  = i_sum[SUM_W-1] ? (SUM_W'(0) - i_sum) : i_sum;
    assign fire = r_s2_nonzero && (CMP_W'(r_s2_mag) > CMP_W'(r_s2_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s2_valid && fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s2_mag     <= mag;
            r_s2_limit   <= PROD_W'(i_threshold) * PROD_W'(i_count);
            r_s2_nonzero <= (i_count != '0);
            r_s2_first   <= i_first;
            r_s2_last    <= i_last;
        end
        if (out_ready) begin
            r_o_first <= r_s2_first;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_first_column = COL_OUT_W'(r_o_first);
    assign o_last_column  = COL_OUT_W'(r_o_last);

endmodule

`default_nettype wire

>>> design/sumthreshold_window_flagger_core.sv
// ----------------------------------------------------------------------------
// sumthreshold_window_flagger_core
// Sliding-window sum-threshold flagger for one line of samples.
//
// Input channel (i_valid / o_stall): one sample item per cycle, in line order.
// A missing sample only advances the column. Other samples enter a window of
// the last window_length such samples, held in a row of cells with the oldest
// entry in cell 0. Once the window is full, a range first..last column is
// produced when |sum| > threshold * count, and the oldest entry leaves.
// Output channel (o_valid / i_stall): zero or one range item per sample.
// Configuration (i_cfg_valid / o_cfg_ready): index 0 window_length, index 1
// threshold; the port is always ready; the user writes it while the block is
// idle; the block does not enforce it. Throughput is one item per cycle: the
// window update (one add and one subtract on the running sum) is combinational.
// Each range item passes three registered stages: the window stage, the
// magnitude and limit multiply stage, and the compare into the output register.
// When the receiver stalls the range item holds; o_stall rises only once all
// three stages hold items. Reset clears the line state, the pipeline and the
// registers (window_length 1, maximum threshold); the cells need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sumthreshold_window_flagger_core
    import stwf_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_LINE   = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [VALUE_W-1:0]    i_sample_value,
    input  wire logic                  i_already_flagged,
    input  wire logic                  i_is_missing,
    input  wire logic                  i_end_of_line,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COL_OUT_W-1:0]       o_first_column,
    output logic [COL_OUT_W-1:0]       o_last_column,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int COL_W  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int SUM_W  = VALUE_W + FILL_W;
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    // Configuration.
    logic [LEN_W-1:0]  r_len;
    logic [THR_W-1:0]  r_thr;

    // Line state.
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [COL_W-1:0]  r_col;

    // Window stage toward the test.
    logic              r_s1_valid;
    logic [SUM_W-1:0]  r_s1_sum;
    logic [FILL_W-1:0] r_s1_count;
    logic [COL_W-1:0]  r_s1_first;
    logic [COL_W-1:0]  r_s1_last;

    logic              accept;
    logic              push;
    logic              pop;
    logic              test_ready;
    logic              s1_ready;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  len_eff;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] target;
    t_cell_ctl         cell_ctl;
    t_entry            new_entry;
    t_entry            old_entry;
    logic [COL_W-1:0]  old_col;
    logic [SUM_W-1:0]  add_v;
    logic [SUM_W-1:0]  sub_v;
    logic [SUM_W-1:0]  sum_p;
    logic [FILL_W-1:0] cnt_p;
    logic [COL_W-1:0]  col_inc;

    t_entry            cell_entry [MAX_WINDOW];
    logic [COL_W-1:0]  cell_col   [MAX_WINDOW];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                CFG_THRESHOLD:     r_thr <= i_cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    assign s1_ready = !r_s1_valid || test_ready;
    assign o_stall  = !s1_ready;
    assign accept   = i_valid && !o_stall;
    assign push     = accept && !i_is_missing;

    // Zero length acts as one; longer than the cell row saturates.
    assign len_ext = CMP_W'(r_len);
    always_comb begin
        if (r_len == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
            len_eff = CMP_W'(MAX_WINDOW);
        end else begin
            len_eff = len_ext;
        end
    end

    assign fill_inc = r_fill + FILL_W'(1);
    assign pop      = CMP_W'(fill_inc) >= len_eff;

    // On a pop the row moves down one place and the new item lands just below
    // the fill mark; with an empty row the new item itself is the one leaving.
    assign target         = pop ? (r_fill - FILL_W'(1)) : r_fill;
    assign cell_ctl.load  = push && !(pop && (r_fill == '0));
    assign cell_ctl.shift = push && pop;

    assign new_entry.value   = i_sample_value;
    assign new_entry.flagged = i_already_flagged;

    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
            t_entry           next_entry;
            logic [COL_W-1:0] next_col;
            if (k == MAX_WINDOW - 1) begin : g_top
                assign next_entry = new_entry;
                assign next_col   = r_col;
            end else begin : g_mid
                assign next_entry = cell_entry[k+1];
                assign next_col   = cell_col[k+1];
            end
            stwf_cell #(
                .CELL_INDEX (k),
                .FILL_W     (FILL_W),
                .COL_W      (COL_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_target     (target),
                .i_new_entry  (new_entry),
                .i_new_col    (r_col),
                .i_next_entry (next_entry),
                .i_next_col   (next_col),
                .o_entry      (cell_entry[k]),
                .o_col        (cell_col[k])
            );
        end
    endgenerate

    assign old_entry = (r_fill == '0) ? new_entry : cell_entry[0];
    assign old_col   = (r_fill == '0) ? r_col : cell_col[0];

    assign add_v = i_already_flagged ? '0 :
                   {{(SUM_W-VALUE_W){i_sample_value[VALUE_W-1]}}, i_sample_value};
    assign sub_v = old_entry.flagged ? '0 :
                   {{(SUM_W-VALUE_W){old_entry.value[VALUE_W-1]}}, old_entry.value};
    assign sum_p = r_sum + add_v;
    assign cnt_p = r_count + FILL_W'(!i_already_flagged);

    assign col_inc = (r_col == COL_W'(MAX_LINE - 1)) ? '0 : (r_col + COL_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_col   <= '0;
        end else if (accept) begin
            if (i_end_of_line) begin
                r_fill  <= '0;
                r_count <= '0;
                r_sum   <= '0;
                r_col   <= '0;
            end else begin
                r_col <= col_inc;
                if (push) begin
                    if (pop) begin
                        r_sum <= sum_p - sub_v;
                        if (!old_entry.flagged && (cnt_p != '0)) begin
                            r_count <= cnt_p - FILL_W'(1);
                        end else begin
                            r_count <= cnt_p;
                        end
                    end else begin
                        r_sum   <= sum_p;
                        r_count <= cnt_p;
                        r_fill  <= fill_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= push && pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_sum   <= sum_p;
            r_s1_count <= cnt_p;
            r_s1_first <= old_col;
            r_s1_last  <= r_col;
        end
    end

    stwf_test #(
        .SUM_W (SUM_W),
        .CNT_W (FILL_W),
        .COL_W (COL_W)
    ) u_test (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_s1_valid),
        .o_ready        (test_ready),
        .i_sum          (r_s1_sum),
        .i_count        (r_s1_count),
        .i_first        (r_s1_first),
        .i_last         (r_s1_last),
        .i_threshold    (r_thr),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_first_column (o_first_column),
        .o_last_column  (o_last_column)
    );

`ifndef SYNTHESIS
    // The row never holds more entries than it has cells.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(MAX_WINDOW))
        else $error("window fill reached the cell count");

    // Only stored entries can be counted.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("counted samples exceed window fill");

    // An accepted end-of-line item leaves an empty line state.
    a_eol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_line) |=> (r_fill == '0 && r_col == '0 && r_sum == '0))
        else $error("line state not cleared after end of line");

    // A missing sample leaves the window untouched.
    a_missing_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_is_missing && !i_end_of_line) |=> ($stable(r_fill) && $stable(r_sum)))
        else $error("missing sample changed the window");

    // Reset empties the result path.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_s1_valid))
        else $error("result pending after reset");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sum-threshold window flagger. Sample items are
// driven from a queue with random sender gaps and receiver stalls. A local
// model of the sliding window predicts every flagged column range. Each range
// item from the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stwf_pkg::*;

    localparam int WIN_DEPTH   = 64;
    localparam int RANDOM_GOAL = 1800;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 flagged;
        bit                 missing;
        bit                 eol;
    } t_sample;

    typedef struct packed {
        logic [COL_OUT_W-1:0] first;
        logic [COL_OUT_W-1:0] last;
    } t_col_range;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [VALUE_W-1:0]    i_sample_value = '0;
    logic                  i_already_flagged = 1'b0;
    logic                  i_is_missing = 1'b0;
    logic                  i_end_of_line = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [COL_OUT_W-1:0]  o_first_column;
    logic [COL_OUT_W-1:0]  o_last_column;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sumthreshold_window_flagger_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample_value    (i_sample_value),
        .i_already_flagged (i_already_flagged),
        .i_is_missing      (i_is_missing),
        .i_end_of_line     (i_end_of_line),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_first_column    (o_first_column),
        .o_last_column     (o_last_column),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Window model state, starting at its reset values.
    logic [VALUE_W-1:0]   win_value [WIN_DEPTH];
    bit                   win_flag [WIN_DEPTH];
    logic [COL_OUT_W-1:0] win_col [WIN_DEPTH];
    logic [5:0]           win_wr_ptr = '0;
    longint               win_sum = 0;
    int unsigned          win_counted = 0;
    int unsigned          win_fill = 0;
    logic [COL_OUT_W-1:0] line_col = '0;
    logic [LEN_W-1:0]     model_len = LEN_RESET;
    logic [THR_W-1:0]     model_thr = THR_RESET;

    t_sample     sample_queue[$];
    t_col_range  expected_ranges[$];
    bit          sample_taken = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned items_queued = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Advance the window by one accepted sample and queue the range it flags.
    task automatic advance_window(input t_sample s);
        logic [COL_OUT_W-1:0] col;
        int unsigned          len;
        logic [5:0]           oldest;
        longint unsigned      mag;
        longint unsigned      limit;
        t_col_range           r;
        col = line_col;
        line_col = line_col + 1'b1;
        if (!s.missing) begin
            len = model_len;
            if (len == 0) len = 1;
            if (len > WIN_DEPTH) len = WIN_DEPTH;
            win_value[win_wr_ptr] = s.value;
            win_flag[win_wr_ptr] = s.flagged;
            win_col[win_wr_ptr] = col;
            win_wr_ptr = win_wr_ptr + 1'b1;
            if (win_fill < WIN_DEPTH) win_fill++;
            if (!s.flagged) begin
                win_sum += longint'(signed'(s.value));
                win_counted++;
            end
            if (win_fill >= len) begin
                oldest = win_wr_ptr - 6'(win_fill);
                mag = (win_sum < 0) ? -win_sum : win_sum;
                limit = model_thr;
                limit = limit * win_counted;
                if (win_counted > 0 && mag > limit) begin
                    r.first = win_col[oldest];
                    r.last = col;
                    expected_ranges.push_back(r);
                end
                if (!win_flag[oldest]) begin
                    win_sum -= longint'(signed'(win_value[oldest]));
                    if (win_counted > 0) win_counted--;
                end
                win_fill--;
            end
        end
        if (s.eol) begin
            win_wr_ptr = '0;
            win_sum = 0;
            win_counted = 0;
            win_fill = 0;
            line_col = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    // Output check first, so a range predicted at this edge is not consumed here.
    always @(posedge i_clk) begin
        t_col_range got;
        t_col_range want;
        t_sample    s;
        if (!i_rst_n) begin
            sample_taken = 1'b0;
        end else begin
            if (o_valid === 1'b1 && i_stall == 1'b0) begin
                got.first = o_first_column;
                got.last = o_last_column;
                if (expected_ranges.size() == 0) begin
                    report_mismatch($sformatf("unexpected range %0d..%0d",
                                              got.first, got.last));
                end else begin
                    want = expected_ranges.pop_front();
                    if (got.first !== want.first)
                        report_mismatch($sformatf("first_column expected %0d got %0d",
                                                  want.first, got.first));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_column expected %0d got %0d",
                                                  want.last, got.last));
                end
            end
            sample_taken = i_valid && !o_stall;
            if (sample_taken) begin
                s.value = i_sample_value;
                s.flagged = i_already_flagged;
                s.missing = i_is_missing;
                s.eol = i_end_of_line;
                advance_window(s);
            end
        end
    end

    always @(negedge i_clk) begin
        t_sample nxt;
        if (i_rst_n && (!i_valid || sample_taken)) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = sample_queue.pop_front();
                i_valid <= 1'b1;
                i_sample_value <= nxt.value;
                i_already_flagged <= nxt.flagged;
                i_is_missing <= nxt.missing;
                i_end_of_line <= nxt.eol;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic push_sample(input logic [VALUE_W-1:0] v, input bit flg,
                               input bit miss, input bit eol);
        t_sample s;
        s.value = v;
        s.flagged = flg;
        s.missing = miss;
        s.eol = eol;
        sample_queue.push_back(s);
        items_queued++;
    endtask

    // Waits until every queued item is taken and every range has come out,
    // then lets the pipeline run dry for items that flag nothing.
    task automatic drain_block();
        do begin
            @(posedge i_clk);
            #1;
        end while (sample_queue.size() != 0 || (i_valid && !sample_taken) ||
                   expected_ranges.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_WINDOW_LENGTH) model_len = data[LEN_W-1:0];
        else if (idx == CFG_THRESHOLD) model_thr = data[THR_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] noise_value(input int unsigned amp);
        int s;
        s = int'($urandom_range(2 * amp)) - int'(amp);
        return s;
    endfunction

    // One line of background noise with interference bursts of one sign.
    task automatic queue_line(input int unsigned n, input int unsigned amp,
                              input bit close);
        int unsigned        burst_left;
        bit                 burst_neg;
        int                 m;
        int unsigned        k;
        logic [VALUE_W-1:0] v;
        bit                 eol;
        burst_left = 0;
        burst_neg = 1'b0;
        for (k = 0; k < n; k++) begin
            if (burst_left == 0 && $urandom_range(99) < 4) begin
                burst_left = $urandom_range(1, 24);
                burst_neg = $urandom_range(1);
            end
            if ($urandom_range(99) < 4) begin
                v = $urandom();
            end else if (burst_left > 0) begin
                m = $urandom_range(amp * 64, amp * 8);
                v = burst_neg ? -m : m;
                burst_left--;
            end else begin
                v = noise_value(amp);
            end
            eol = close && (k == n - 1);
            if ($urandom_range(199) == 0) eol = 1'b1;
            push_sample(v, $urandom_range(99) < 10, $urandom_range(99) < 10, eol);
        end
    endtask

    task automatic pick_settings(input int unsigned amp);
        int unsigned pick;
        logic [LEN_W-1:0] len;
        logic [THR_W-1:0] thr;
        pick = $urandom_range(9);
        if (pick < 3) len = LEN_W'($urandom_range(1, 8));
        else if (pick < 6) len = LEN_W'($urandom_range(9, 64));
        else if (pick == 6) len = LEN_W'(1);
        else if (pick == 7) len = LEN_W'(64);
        else if (pick == 8) len = '0;
        else len = LEN_W'($urandom_range(65, 127));
        pick = $urandom_range(19);
        if (pick < 9) thr = THR_W'($urandom_range(amp, amp / 16));
        else if (pick < 12) thr = '0;
        else if (pick < 15) thr = THR_RESET;
        else if (pick < 17) thr = THR_W'($urandom());
        else thr = THR_W'($urandom_range(1, 16));
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    endtask

    initial begin
        int unsigned phase;
        int unsigned start_count;
        int unsigned phase_start;
        int unsigned amp;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero length acts as one; a zero threshold flags any nonzero sum.
        write_reg(CFG_WINDOW_LENGTH, 0);
        write_reg(CFG_THRESHOLD, 0);
        push_sample(32'd5, 0, 0, 0);
        push_sample(32'd0, 0, 0, 0);
        push_sample(32'h8000_0000, 0, 0, 0);
        push_sample(32'hFFFF_FFFF, 1, 0, 0);
        push_sample(32'd9, 0, 1, 0);
        push_sample(32'h7FFF_FFFF, 0, 1, 1);
        drain_block();

        // Oversized length saturates; a line shorter than the window is quiet.
        write_reg(CFG_WINDOW_LENGTH, 127);
        write_reg(CFG_THRESHOLD, THR_RESET);
        push_sample(32'd1, 0, 0, 0);
        push_sample(32'd2, 0, 0, 0);
        push_sample(32'h7FFF_FFFF, 0, 0, 1);
        drain_block();

        // Sums at the extremes against the largest threshold.
        write_reg(CFG_WINDOW_LENGTH, 2);
        push_sample(32'h7FFF_FFFF, 0, 0, 0);
        push_sample(32'h7FFF_FFFF, 0, 0, 0);
        push_sample(32'h8000_0000, 0, 0, 0);
        push_sample(32'h8000_0000, 0, 0, 1);
        drain_block();

        // A shorter length set mid-line keeps testing the longer window.
        write_reg(CFG_WINDOW_LENGTH, 4);
        write_reg(CFG_THRESHOLD, 0);
        repeat (6) push_sample(32'd1, 0, 0, 0);
        drain_block();
        write_reg(CFG_WINDOW_LENGTH, 1);
        push_sample(32'hFFFF_FFFF, 0, 0, 0);
        push_sample(32'hFFFF_FFFF, 1, 0, 0);
        push_sample(32'hFFFF_FFFF, 0, 0, 1);
        drain_block();

        start_count = items_queued;
        phase = 0;
        while (items_queued - start_count < RANDOM_GOAL) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            case ($urandom_range(2))
                0: amp = 16;
                1: amp = 1000;
                default: amp = 100000;
            endcase
            pick_settings(amp);
            phase_start = items_queued;
            while (items_queued - phase_start < 150) begin
                if ($urandom_range(19) == 0) queue_line($urandom_range(200, 600), amp, 1);
                else queue_line($urandom_range(1, 200), amp, 1);
            end
            // Sometimes leave a line open so the next settings land mid-line.
            if ($urandom_range(2) == 0) queue_line($urandom_range(10, 80), amp, 0);
            drain_block();
            phase++;
        end

        if (mismatches == 0 && expected_ranges.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
